### rtl/xeu_pkg.sv
// Shared types, constants and entity tables of the XML entity unescaper.
package xeu_pkg;

    localparam int HOLD_DEPTH = 5;
    localparam int NUM_ENTS   = 5;
    localparam int LIST_DEPTH = 7;

    localparam logic [7:0] CHAR_LT   = 8'h3C;
    localparam logic [7:0] CHAR_GT   = 8'h3E;
    localparam logic [7:0] CHAR_QUOT = 8'h22;
    localparam logic [7:0] CHAR_APOS = 8'h27;
    localparam logic [7:0] CHAR_AMP  = 8'h26;

    localparam logic [7:0] ENT_CHAR [NUM_ENTS] = '{CHAR_LT, CHAR_GT, CHAR_QUOT, CHAR_APOS,
                                                   CHAR_AMP};
    localparam logic [2:0] ENT_LEN  [NUM_ENTS] = '{3'd3, 3'd3, 3'd5, 3'd5, 3'd4};

    // Configuration register index.
    localparam logic REG_OUT_CAPACITY = 1'b0;

    localparam logic [15:0] CAPACITY_RESET = 16'd4096;

    // The up to seven result items that one accepted item causes, in order.
    typedef struct packed {
        logic [LIST_DEPTH-1:0][7:0] data;
        logic [LIST_DEPTH-1:0]      is_end;
        logic [2:0]                 count;
    } xeu_list_t;

    // Expected byte of entity ent after the '&', at position pos.
    function automatic logic [7:0] ent_body_char(input logic [2:0] ent, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (ent)
            3'd0: begin
                case (pos)
                    3'd0:    ch = 8'h6C;
                    3'd1:    ch = 8'h74;
                    3'd2:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            end
            3'd1: begin
                case (pos)
                    3'd0:    ch = 8'h67;
                    3'd1:    ch = 8'h74;
                    3'd2:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            end
            3'd2: begin
                case (pos)
                    3'd0:    ch = 8'h71;
                    3'd1:    ch = 8'h75;
                    3'd2:    ch = 8'h6F;
                    3'd3:    ch = 8'h74;
                    3'd4:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            end
            3'd3: begin
                case (pos)
                    3'd0:    ch = 8'h61;
                    3'd1:    ch = 8'h70;
                    3'd2:    ch = 8'h6F;
                    3'd3:    ch = 8'h73;
                    3'd4:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            end
            3'd4: begin
                case (pos)
                    3'd0:    ch = 8'h61;
                    3'd1:    ch = 8'h6D;
                    3'd2:    ch = 8'h70;
                    3'd3:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/xml_entity_unescaper_top.sv
// Top level of the XML predefined-entity decoder with its APB register port.
// Throughput: one item per cycle while the receiver keeps up and no item queues more than
// one entry; an item queuing more entries (result items or dropped bytes) holds off the
// next item until its last entry leaves the queue. Reset (rst_n, asynchronous, active low)
// empties the queue, clears the match and counters, and sets out_capacity to 4096.
module xml_entity_unescaper_top
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        last,
    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        is_end,
    output logic        overflow,
    // APB register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The counter is compared against a 16-bit limit, so both are widened to the
    // larger of the two widths.
    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    xeu_pkg::xeu_list_t list;

    // Result queue: the result items of the item being worked on, head at entry 0.
    logic [xeu_pkg::LIST_DEPTH-1:0][7:0] pend_data_reg;
    logic [xeu_pkg::LIST_DEPTH-1:0]      pend_end_reg;
    logic [2:0]                          pend_cnt_reg;

    logic [COUNT_WIDTH-1:0] written_reg;
    logic                   dropped_reg;
    logic [15:0]            cap_reg;

    logic       out_valid_reg;
    logic [7:0] data_reg;
    logic       is_end_reg;
    logic       overflow_reg;

    logic        in_fire;
    logic        drain_fire;
    logic        load_out;
    logic        fits;
    logic [15:0] limit;
    logic [7:0]  head_data;
    logic        head_end;
    logic        cfg_write;

    xeu_parse u_parse
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_fire),
        .in_byte (in_byte),
        .last    (last),
        .list    (list)
    );

    assign head_data = pend_data_reg[0];
    assign head_end  = pend_end_reg[0];

    // The head of the queue moves on whenever the output register is free or is
    // being emptied in this cycle.
    assign drain_fire = (pend_cnt_reg != 3'd0) && (!out_valid_reg || !out_stall);

    // A capacity of zero behaves like one: no decoded byte fits.
    assign limit = (cap_reg == 16'd0) ? 16'd0 : (cap_reg - 16'd1);
    assign fits  = CMP_W'(written_reg) < CMP_W'(limit);

    // Dropped bytes are drained from the queue like others but never reach the output register.
    assign load_out = drain_fire && (head_end || fits);

    // A new item may enter when the queue is empty or its last entry leaves now.
    assign in_stall = !((pend_cnt_reg == 3'd0) || ((pend_cnt_reg == 3'd1) && drain_fire));
    assign in_fire  = in_valid && !in_stall;

    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg  <= 3'd0;
            written_reg   <= '0;
            dropped_reg   <= 1'b0;
            cap_reg       <= xeu_pkg::CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                pend_cnt_reg <= list.count;
            end
            else if (drain_fire)
            begin
                pend_cnt_reg <= pend_cnt_reg - 3'd1;
            end

            // The end item closes the string and restarts the byte count.
            if (drain_fire)
            begin
                if (head_end)
                begin
                    written_reg <= '0;
                    dropped_reg <= 1'b0;
                end
                else if (fits)
                begin
                    if (written_reg != '1)
                    begin
                        written_reg <= written_reg + 1'b1;
                    end
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write && (paddr[2] == xeu_pkg::REG_OUT_CAPACITY))
            begin
                cap_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_data_reg <= list.data;
            pend_end_reg  <= list.is_end;
        end
        else if (drain_fire)
        begin
            pend_data_reg <= pend_data_reg >> 8;
            pend_end_reg  <= pend_end_reg >> 1;
        end

        if (load_out)
        begin
            data_reg     <= head_end ? 8'h00 : head_data;
            is_end_reg   <= head_end;
            overflow_reg <= head_end && dropped_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_byte = data_reg;
    assign is_end    = is_end_reg;
    assign overflow  = overflow_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == xeu_pkg::REG_OUT_CAPACITY) ? {16'h0000, cap_reg} : 32'h0;

`ifndef SYNTHESIS
    // An accepted item fills the queue with exactly the results it causes.
    a_queue_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (pend_cnt_reg == $past(list.count)))
        else $error("result queue count does not match the loaded item");

    // Leaving the end item restarts the byte count and the drop flag.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_fire && head_end) |=> ((written_reg == '0) && !dropped_reg))
        else $error("counters not cleared after the end item");

    // A byte that does not fit marks the string as overflowed.
    a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_fire && !head_end && !fits) |=> dropped_reg)
        else $error("dropped byte did not set the overflow flag");

    // Only the end item can report overflow.
    a_ovf_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !is_end_reg) |-> !overflow_reg)
        else $error("overflow set on a data item");
`endif

endmodule

### rtl/xeu_parse.sv
// Entity matcher: holds the partial match and builds the result list of one item.
module xeu_parse
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              last,
    output xeu_pkg::xeu_list_t list
);

    logic [xeu_pkg::HOLD_DEPTH-1:0][7:0] hb_reg;
    logic [xeu_pkg::HOLD_DEPTH-1:0][7:0] hb_next;
    logic [2:0]                          hc_reg;
    logic [2:0]                          hc_next;
    logic [xeu_pkg::NUM_ENTS-1:0]        alive_reg;
    logic [xeu_pkg::NUM_ENTS-1:0]        alive_next;

    logic [2:0]                   pos;
    logic [xeu_pkg::NUM_ENTS-1:0] match;
    logic [xeu_pkg::NUM_ENTS-1:0] done;
    logic [xeu_pkg::NUM_ENTS-1:0] next_alive;
    logic [7:0]                   done_char;
    logic [2:0]                   flush_cnt;
    logic                         emit_v;
    logic [7:0]                   emit_b;

    assign pos = hc_reg - 3'd1;

    always_comb
    begin
        done_char = 8'h00;
        for (int e = 0; e < xeu_pkg::NUM_ENTS; e++)
        begin
            match[e] = alive_reg[e] && (pos < xeu_pkg::ENT_LEN[e])
                       && (xeu_pkg::ent_body_char(3'(e), pos) == in_byte);
            done[e]       = match[e] && ((pos + 3'd1) == xeu_pkg::ENT_LEN[e]);
            next_alive[e] = match[e] && !done[e];
            if (done[e])
            begin
                done_char = xeu_pkg::ENT_CHAR[e];
            end
        end
    end

    // Next match state and what goes out before it.
    always_comb
    begin
        flush_cnt  = 3'd0;
        emit_v     = 1'b0;
        emit_b     = in_byte;
        hc_next    = hc_reg;
        alive_next = alive_reg;
        hb_next    = hb_reg;
        if (hc_reg == 3'd0)
        begin
            if (in_byte == xeu_pkg::CHAR_AMP)
            begin
                hc_next    = 3'd1;
                alive_next = '1;
                hb_next[0] = in_byte;
            end
            else
            begin
                emit_v = 1'b1;
            end
        end
        else if (|done)
        begin
            hc_next    = 3'd0;
            alive_next = '0;
            emit_v     = 1'b1;
            emit_b     = done_char;
        end
        else if ((|next_alive) && (hc_reg < 3'(xeu_pkg::HOLD_DEPTH)))
        begin
            hb_next[hc_reg] = in_byte;
            hc_next         = hc_reg + 3'd1;
            alive_next      = next_alive;
        end
        else
        begin
            flush_cnt = hc_reg;
            if (in_byte == xeu_pkg::CHAR_AMP)
            begin
                hc_next    = 3'd1;
                alive_next = '1;
                hb_next[0] = in_byte;
            end
            else
            begin
                hc_next    = 3'd0;
                alive_next = '0;
                emit_v     = 1'b1;
            end
        end
    end

    // Lay the results out in order: flushed bytes, the emitted byte, and on the
    // final item the bytes still held plus the end item.
    always_comb
    begin
        logic [2:0] k;
        list = '0;
        for (int i = 0; i < xeu_pkg::HOLD_DEPTH; i++)
        begin
            if (3'(i) < flush_cnt)
            begin
                list.data[i] = hb_reg[i];
            end
        end
        k = flush_cnt;
        if (emit_v)
        begin
            list.data[k] = emit_b;
            k = k + 3'd1;
        end
        if (last)
        begin
            for (int i = 0; i < xeu_pkg::HOLD_DEPTH; i++)
            begin
                if (3'(i) < hc_next)
                begin
                    list.data[k + 3'(i)] = hb_next[i];
                end
            end
            k = k + hc_next;
            list.is_end[k] = 1'b1;
            k = k + 3'd1;
        end
        list.count = k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg    <= 3'd0;
            alive_reg <= '0;
        end
        else if (accept)
        begin
            hc_reg    <= last ? 3'd0 : hc_next;
            alive_reg <= last ? '0 : alive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hb_reg <= hb_next;
        end
    end

endmodule
